// ===== src/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants for the quaternion to Euler angle unit
// Holds the CORDIC arctangent table and the fixed angle widths.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // angle accumulator width, 2^31 = pi
  localparam int ANG_W = 32;
  // output binary angle width, 2^15 = pi
  localparam int BAM_W = 16;
  // number of table entries
  localparam int TAB_N = 32;

  // atan(2^-i) in units of 2^-31 pi
  localparam logic [ANG_W-1:0] ATAN_TAB [TAB_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // half turn start value for a negated vector
  localparam logic [ANG_W-1:0] ANG_PI = 32'h80000000;
  // rounding offset for the 16-bit angle
  localparam logic [ANG_W-1:0] BAM_RND = 32'h00008000;
  // pitch limits, a quarter turn
  localparam logic signed [BAM_W-1:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [BAM_W-1:0] PITCH_MIN = -16'sd16384;

endpackage

// ===== src/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one digit of a pipelined integer square root
// Consumes the top two bits of the radicand and resolves one root bit.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int NW = 32,
  parameter int RW = 19,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] root_i,
  output logic [NW-1:0] n_o,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] root_o
);

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic [NW-1:0] n_nxt;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] root_nxt;
  logic [NW-1:0] n_r;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] root_r;

  // restoring step: try (root << 2) | 1 against the shifted remainder
  always_comb begin
    rem_sh = {rem_i[RW-3:0], n_i[NW-1:NW-2]};
    trial  = (RW'(root_i) << 2) | RW'(1);
    n_nxt  = n_i << 2;
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign n_o    = n_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ===== src/q2e_vec_prep.sv =====
// ----------------------------------------------------------------------------
// q2e_vec_prep: vector setup ahead of a CORDIC chain
// Folds a left-half-plane vector into the right half and flags (0,0).
// ----------------------------------------------------------------------------
module q2e_vec_prep #(
  parameter int XW = 21
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [XW-1:0]        x_i,
  input  logic signed [XW-1:0]        y_i,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output logic [q2e_pkg::ANG_W-1:0]   z_o,
  output logic                        zero_o
);

  logic signed [XW-1:0]      x_nxt, y_nxt, x_r, y_r;
  logic [q2e_pkg::ANG_W-1:0] z_nxt, z_r;
  logic                      zero_nxt, zero_r;

  // negate a left-half-plane vector into the right half and start at pi, else start at zero
  always_comb begin
    zero_nxt = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_nxt = -x_i;
      y_nxt = -y_i;
      z_nxt = q2e_pkg::ANG_PI;
    end else begin
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

// ===== src/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-STAGE) and updates the angle.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int XW    = 21,
  parameter int STAGE = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [XW-1:0]        x_i,
  input  logic signed [XW-1:0]        y_i,
  input  logic [q2e_pkg::ANG_W-1:0]   z_i,
  input  logic                        zero_i,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output logic [q2e_pkg::ANG_W-1:0]   z_o,
  output logic                        zero_o
);

  localparam logic [q2e_pkg::ANG_W-1:0] ATAN_K = q2e_pkg::ATAN_TAB[STAGE];

  logic signed [XW-1:0]      xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic [q2e_pkg::ANG_W-1:0] z_nxt, z_r;
  logic                      zero_r;

  // direction follows the sign of y
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_K;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

// ===== src/quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit: attitude quaternion to ZYX Euler angles
// Products, a pipelined square root and three CORDIC chains give roll,
// pitch and yaw as binary angles.
// ----------------------------------------------------------------------------
// channel  | ports                                         | direction
// in       | in_valid, in_ready, in_quat_w/x/y/z           | input
// out      | out_valid, out_ready, out_roll/pitch/yaw_angle,| output
//          | out_pitch_clamped                             |
//
// One quaternion is taken every cycle while the output does not stall; the
// pipeline runs through the products, the square root cells (one root bit
// each), the vector setup, the CORDIC cells (one rotation each) and the output.
// Synchronous active-low reset clears the valid bits only.
// A stall at the output freezes the whole pipeline; in_ready follows.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_roll_angle,
  output logic signed [15:0]                out_pitch_angle,
  output logic signed [15:0]                out_yaw_angle,
  output logic                              out_pitch_clamped
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int F   = CW - 1;
  localparam int PW  = 2 * CW;
  localparam int SW  = CW + 3;
  localparam int XW  = CW + 5;
  localparam int NW  = 2 * CW;
  localparam int RW  = CW + 3;
  localparam int NST = CORDIC_STEPS;
  localparam int AW  = q2e_pkg::ANG_W;
  localparam int BW  = q2e_pkg::BAM_W;
  localparam int L   = CW + NST + 5;
  localparam int SDW = 4 * SW + CW + 2;

  localparam logic signed [SW-1:0] ONE_S  = SW'(1) << F;
  localparam logic [NW-1:0]        ONE_SQ = NW'(1) << (2 * F);

  // product floored to F fraction bits
  function automatic logic signed [CW:0] pmul(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    logic signed [PW-1:0] full;
    full = PW'(a) * PW'(b);
    full = full >>> F;
    return full[CW:0];
  endfunction

  // ---- flow control ----
  logic         adv;
  logic [L-1:0] vld_r, vld_nxt;

  assign adv      = out_ready || !vld_r[L-1];
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[L-2:0], in_valid && in_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---- stage 0: products ----
  logic signed [CW:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r, p_wx_r, p_yz_r;
  logic signed [CW:0] p_wz_r, p_xy_r, p_wy_r, p_xz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww_r <= pmul(in_quat_w, in_quat_w);
      p_xx_r <= pmul(in_quat_x, in_quat_x);
      p_yy_r <= pmul(in_quat_y, in_quat_y);
      p_zz_r <= pmul(in_quat_z, in_quat_z);
      p_wx_r <= pmul(in_quat_w, in_quat_x);
      p_yz_r <= pmul(in_quat_y, in_quat_z);
      p_wz_r <= pmul(in_quat_w, in_quat_z);
      p_xy_r <= pmul(in_quat_x, in_quat_y);
      p_wy_r <= pmul(in_quat_w, in_quat_y);
      p_xz_r <= pmul(in_quat_x, in_quat_z);
    end
  end

  // ---- stage 1: quadratic forms and arcsine clamp ----
  logic signed [SW-1:0] rn_nxt, rd_nxt, yn_nxt, yd_nxt, s_raw;
  logic signed [CW:0]   s_nxt;
  logic                 clp_nxt;
  logic [CW-1:0]        mag_nxt;
  logic signed [SW-1:0] rn_r, rd_r, yn_r, yd_r;
  logic signed [CW:0]   s_r;
  logic                 clp_r;
  logic [CW-1:0]        mag_r;

  always_comb begin
    rn_nxt = (SW'(p_wx_r) + SW'(p_yz_r)) <<< 1;
    rd_nxt = SW'(p_ww_r) + SW'(p_zz_r) - SW'(p_xx_r) - SW'(p_yy_r);
    yn_nxt = (SW'(p_wz_r) + SW'(p_xy_r)) <<< 1;
    yd_nxt = SW'(p_ww_r) + SW'(p_xx_r) - SW'(p_yy_r) - SW'(p_zz_r);
    s_raw  = (SW'(p_wy_r) - SW'(p_xz_r)) <<< 1;
    clp_nxt = 1'b0;
    if (s_raw > ONE_S) begin
      s_raw   = ONE_S;
      clp_nxt = 1'b1;
    end else if (s_raw < -ONE_S) begin
      s_raw   = -ONE_S;
      clp_nxt = 1'b1;
    end
    s_nxt = s_raw[CW:0];
    if (s_nxt < 0) begin
      mag_nxt = CW'(-s_raw);
    end else begin
      mag_nxt = CW'(s_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rn_r  <= rn_nxt;
      rd_r  <= rd_nxt;
      yn_r  <= yn_nxt;
      yd_r  <= yd_nxt;
      s_r   <= s_nxt;
      clp_r <= clp_nxt;
      mag_r <= mag_nxt;
    end
  end

  // ---- stage 2: radicand for the pitch cosine ----
  logic [NW-1:0]  n0_r;
  logic [SDW-1:0] side_r [CW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      n0_r      <= ONE_SQ - (NW'(mag_r) * NW'(mag_r));
      side_r[0] <= {rn_r, rd_r, yn_r, yd_r, s_r, clp_r};
    end
  end

  // ---- square root cells, side data rides along ----
  logic [NW-1:0] sq_n   [CW+1];
  logic [RW-1:0] sq_rem [CW+1];
  logic [CW-1:0] sq_rt  [CW+1];

  assign sq_n[0]   = n0_r;
  assign sq_rem[0] = '0;
  assign sq_rt[0]  = '0;

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    q2e_sqrt_cell #(.NW(NW), .RW(RW), .QW(CW)) u_cell (
      .clk    (clk),
      .en     (adv),
      .n_i    (sq_n[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_rt[k]),
      .n_o    (sq_n[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_rt[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // ---- unpack aligned operands ----
  logic signed [SW-1:0] a_rn, a_rd, a_yn, a_yd;
  logic signed [CW:0]   a_s;
  logic                 a_clp;
  logic signed [XW-1:0] vx [3];
  logic signed [XW-1:0] vy [3];

  assign {a_rn, a_rd, a_yn, a_yd, a_s, a_clp} = side_r[CW];

  // index 0 roll, 1 pitch, 2 yaw
  assign vx[0] = XW'(a_rd);
  assign vy[0] = XW'(a_rn);
  assign vx[1] = XW'(signed'({1'b0, sq_rt[CW]}));
  assign vy[1] = XW'(a_s);
  assign vx[2] = XW'(a_yd);
  assign vy[2] = XW'(a_yn);

  // ---- three CORDIC chains ----
  logic signed [XW-1:0] cx [3][NST+1];
  logic signed [XW-1:0] cy [3][NST+1];
  logic [AW-1:0]        cz [3][NST+1];
  logic                 c0 [3][NST+1];
  logic                 clp_d_r [NST+1];

  for (genvar v = 0; v < 3; v++) begin : g_vec
    q2e_vec_prep #(.XW(XW)) u_prep (
      .clk    (clk),
      .en     (adv),
      .x_i    (vx[v]),
      .y_i    (vy[v]),
      .x_o    (cx[v][0]),
      .y_o    (cy[v][0]),
      .z_o    (cz[v][0]),
      .zero_o (c0[v][0])
    );

    for (genvar i = 0; i < NST; i++) begin : g_cell
      q2e_cordic_cell #(.XW(XW), .STAGE(i)) u_cell (
        .clk    (clk),
        .en     (adv),
        .x_i    (cx[v][i]),
        .y_i    (cy[v][i]),
        .z_i    (cz[v][i]),
        .zero_i (c0[v][i]),
        .x_o    (cx[v][i+1]),
        .y_o    (cy[v][i+1]),
        .z_o    (cz[v][i+1]),
        .zero_o (c0[v][i+1])
      );
    end
  end

  // clamp flag follows the chains
  always_ff @(posedge clk) begin
    if (adv) begin
      clp_d_r[0] <= a_clp;
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_clp
    always_ff @(posedge clk) begin
      if (adv) begin
        clp_d_r[i+1] <= clp_d_r[i];
      end
    end
  end

  // ---- output stage: round to 16 bits, limit pitch ----
  logic [AW-1:0]          zr [3];
  logic signed [BW-1:0]   bam [3];
  logic signed [BW-1:0]   pitch_nxt;
  logic signed [BW-1:0]   roll_r, pitch_r, yaw_r;
  logic                   clp_out_r;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      zr[v] = cz[v][NST] + q2e_pkg::BAM_RND;
      if (c0[v][NST]) begin
        bam[v] = '0;
      end else begin
        bam[v] = zr[v][AW-1:AW-BW];
      end
    end
    pitch_nxt = bam[1];
    if (pitch_nxt > q2e_pkg::PITCH_MAX) begin
      pitch_nxt = q2e_pkg::PITCH_MAX;
    end else if (pitch_nxt < q2e_pkg::PITCH_MIN) begin
      pitch_nxt = q2e_pkg::PITCH_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r    <= bam[0];
      pitch_r   <= pitch_nxt;
      yaw_r     <= bam[2];
      clp_out_r <= clp_d_r[NST];
    end
  end

  assign out_valid         = vld_r[L-1];
  assign out_roll_angle    = roll_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = clp_out_r;

  // ---- assertions ----
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= q2e_pkg::PITCH_MAX) &&
                  (out_pitch_angle >= q2e_pkg::PITCH_MIN))
    else $error("pitch outside a quarter turn");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow pipeline advance");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

endmodule

// ===== bench/quaternion_to_euler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit_tb: self-checking bench for the Euler angle unit
// Drives quaternions over a valid/ready channel with bursty traffic and a
// stalling receiver, predicts roll, pitch and yaw with a bit-exact CORDIC
// model and compares every output transaction in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit_tb;

  localparam int CW    = 16;
  localparam int STEPS = 16;
  localparam int LAT   = CW + STEPS + 5;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic out_pitch_clamped;

  euler_t angles_due[$];
  int     errors = 0;
  int     hold_cycles = 0;  // receiver hold-off request, counted in its own process

  quaternion_to_euler_unit #(.CORDIC_STEPS(STEPS), .COMPONENT_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_pitch_clamped(out_pitch_clamped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // floored Q1.15 product
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> (CW - 1);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r += longint'(1) << b;
    end
    return r;
  endfunction

  // vectoring CORDIC, 2^31 = pi
  function automatic logic [31:0] cordic_angle(longint vy, longint vx);
    logic [31:0] acc;
    longint xs, ys;
    acc = '0;
    if (vx == 0 && vy == 0) return '0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      acc = q2e_pkg::ANG_PI;
    end
    for (int i = 0; i < STEPS && i < q2e_pkg::TAB_N; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx = vx + ys;
        vy = vy - xs;
        acc = acc + q2e_pkg::ATAN_TAB[i];
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        acc = acc - q2e_pkg::ATAN_TAB[i];
      end
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] to_bam(logic [31:0] a);
    logic [31:0] t;
    t = a + q2e_pkg::BAM_RND;
    return t[31:16];
  endfunction

  function automatic euler_t predict_euler(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                                           logic signed [CW-1:0] qy, logic signed [CW-1:0] qz);
    euler_t e;
    longint w, x, y, z, one, ww, xx, yy, zz, s, m;
    logic signed [15:0] p;
    w = qw; x = qx; y = qy; z = qz;
    one = longint'(1) << (CW - 1);
    ww = qmul(w, w); xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
    s = 2 * (qmul(w, y) - qmul(x, z));
    e.clamped = 1'b0;
    if (s > one) begin
      s = one;
      e.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one;
      e.clamped = 1'b1;
    end
    m = (s < 0) ? -s : s;
    e.roll = to_bam(cordic_angle(2 * (qmul(w, x) + qmul(y, z)), ww + zz - xx - yy));
    e.yaw  = to_bam(cordic_angle(2 * (qmul(w, z) + qmul(x, y)), ww + xx - yy - zz));
    p = to_bam(cordic_angle(s, int_sqrt(one * one - m * m)));
    if (p > q2e_pkg::PITCH_MAX) p = q2e_pkg::PITCH_MAX;
    if (p < q2e_pkg::PITCH_MIN) p = q2e_pkg::PITCH_MIN;
    e.pitch = p;
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // one transaction on the input channel, held until accepted
  task automatic send_quat(logic [CW-1:0] w, logic [CW-1:0] x, logic [CW-1:0] y,
                           logic [CW-1:0] z);
    in_valid  <= 1'b1;
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    angles_due.push_back(predict_euler(w, x, y, z));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (angles_due.size() != 0) @(posedge clk);
  endtask

  // a unit-norm-ish quaternion with random signs and magnitudes, or raw random components
  task automatic send_random_quat();
    int mode;
    real a, b, c, d, n;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send_quat(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    end else begin
      a = $urandom_range(0, 65535) - 32768.0;
      b = $urandom_range(0, 65535) - 32768.0;
      c = $urandom_range(0, 65535) - 32768.0;
      d = $urandom_range(0, 65535) - 32768.0;
      if (mode == 2) begin
        // near gimbal lock: w*y - x*z close to one half
        c = a; d = -b;
      end
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(CW'(int'(a / n * 32767.0)), CW'(int'(b / n * 32767.0)),
                CW'(int'(c / n * 32767.0)), CW'(int'(d / n * 32767.0)));
    end
  endtask

  // receiver: own stall pattern plus requested hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // checker for each output transaction
  initial begin
    euler_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = angles_due.pop_front();
          if (out_roll_angle !== want.roll) report_mismatch("roll", out_roll_angle, want.roll);
          if (out_pitch_angle !== want.pitch)
            report_mismatch("pitch", out_pitch_angle, want.pitch);
          if (out_yaw_angle !== want.yaw) report_mismatch("yaw", out_yaw_angle, want.yaw);
          if (out_pitch_clamped !== want.clamped)
            report_mismatch("pitch_clamped", out_pitch_clamped, want.clamped);
        end
      end
    end
  end

  task automatic test_directed();
    logic [CW-1:0] ext [4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    send_quat('0, '0, '0, '0);                     // zero roll and yaw vectors
    send_quat(16'h7FFF, '0, '0, '0);               // identity
    send_quat('0, 16'h7FFF, '0, '0);               // roll of a half turn
    send_quat('0, '0, '0, 16'h7FFF);               // yaw of a half turn
    send_quat('0, 16'h8000, '0, '0);               // negative abscissa, angle pi
    send_quat(16'h5A82, '0, 16'h5A82, '0);         // pitch at plus a quarter
    send_quat(16'h5A82, '0, 16'hA57E, '0);         // pitch at minus a quarter
    send_quat(16'h7FFF, '0, 16'h7FFF, '0);         // argument beyond one
    send_quat(16'h7FFF, '0, 16'h8000, '0);         // argument beyond minus one
    for (int i = 0; i < 4; i++) send_quat(ext[i], ext[3 - i], ext[(i + 1) % 4], ext[i]);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    wait_drained();
  endtask

  task automatic test_random_bursts(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && n > 0; i++, n--) send_random_quat();
      idle_input($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3 * LAT;  // receiver holds off while the sender keeps offering
    for (int i = 0; i < 2 * LAT; i++) send_random_quat();
    wait_drained();         // sender pauses until everything has come out
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_bursts(1650);
    wait_drained();
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("quaternion_to_euler_unit_tb OK");
    end else begin
      $display("quaternion_to_euler_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("quaternion_to_euler_unit_tb NOT OK");
    $finish;
  end

endmodule
